@@ rtl/environmental_sensor_compensation_assert.svh @@
// assertion macros shared by the checker files
`ifndef ENVIRONMENTAL_SENSOR_COMPENSATION_ASSERT_SVH
`define ENVIRONMENTAL_SENSOR_COMPENSATION_ASSERT_SVH

// property checked at every clock edge outside reset
`define ESC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition in one cycle implies the expectation in the next
`define ESC_ASSERT_NEXT(label, clk, rst, cond, want, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (want)) \
      else $error(msg);

`endif

@@ rtl/esc_pkg.sv @@
package esc_pkg;

   localparam int WORD_W = 64;
   localparam int HALF_W = 32;

   localparam int RAW_T_W = 20;
   localparam int RAW_P_W = 20;
   localparam int RAW_H_W = 16;
   localparam int TEMP_W  = 18;
   localparam int PRESS_W = 32;
   localparam int HUM_W   = 17;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_USER_W = 1;
   localparam int RSP_PRESS_LSB = TEMP_W;
   localparam int RSP_HUM_LSB   = TEMP_W + PRESS_W;
   localparam int RSP_USED_W    = TEMP_W + PRESS_W + HUM_W;

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_TEMP     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PRESS_LO = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PRESS_HI = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_HUM_LO   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_HUM_HI   = 3'd4;

   localparam int MUL_LAT   = 2;
   localparam int DIV_LAT   = WORD_W + 2;
   // stage 13 holds divider operands and the finished humidity
   localparam int FRONT_LAT = 13;
   localparam int LATENCY   = FRONT_LAT + DIV_LAT + 2 * MUL_LAT + 3;
   localparam int TEMP_ALIGN = FRONT_LAT - 5;
   localparam int SIDE_DEPTH = LATENCY - FRONT_LAT - 1;

   localparam logic signed [26:0] FINE_OFF_P = 27'sd128000;
   localparam logic [31:0] FINE_OFF_H  = 32'd76800;
   localparam logic [31:0] HUM_MAX     = 32'd419430400;
   localparam logic [HUM_W-1:0] HUM_FULL = 17'd102400;
   localparam logic [20:0] PA_BASE     = 21'd1048576;
   localparam logic [WORD_W-1:0] PRESS_SCALE = 64'd3125;

endpackage

@@ rtl/esc_delay.sv @@
module esc_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];
endmodule

@@ rtl/esc_mul64.sv @@
module esc_mul64 (
   input  logic                       clock,
   input  logic                       en,
   input  logic [esc_pkg::WORD_W-1:0] a,
   input  logic [esc_pkg::WORD_W-1:0] b,
   output logic [esc_pkg::WORD_W-1:0] p
);
   import esc_pkg::*;

   logic [WORD_W-1:0] ll_ff;
   logic [HALF_W-1:0] lh_ff;
   logic [HALF_W-1:0] hl_ff;
   logic [WORD_W-1:0] p_ff;
   logic [HALF_W-1:0] cross_in;

   // low 64 bits of the product from three 32x32 partial products
   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= WORD_W'(a[HALF_W-1:0]) * WORD_W'(b[HALF_W-1:0]);
         lh_ff <= a[HALF_W-1:0] * b[WORD_W-1:HALF_W];
         hl_ff <= a[WORD_W-1:HALF_W] * b[HALF_W-1:0];
      end
   end

   assign cross_in = lh_ff + hl_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= ll_ff + {cross_in, {HALF_W{1'b0}}};
      end
   end

   assign p = p_ff;
endmodule

@@ rtl/esc_div.sv @@
module esc_div (
   input  logic                       clock,
   input  logic                       en,
   input  logic [esc_pkg::WORD_W-1:0] num,
   input  logic [esc_pkg::WORD_W-1:0] den,
   output logic [esc_pkg::WORD_W-1:0] quo
);
   import esc_pkg::*;

   logic [WORD_W-1:0] rem_ff [WORD_W+1];
   logic [WORD_W-1:0] quo_ff [WORD_W+1];
   logic [WORD_W-1:0] den_ff [WORD_W+1];
   logic              neg_ff [WORD_W+1];
   logic [WORD_W-1:0] res_ff;

   // operands go in as magnitudes, sign fixed at the end
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         quo_ff[0] <= num[WORD_W-1] ? (~num + 1'b1) : num;
         den_ff[0] <= den[WORD_W-1] ? (~den + 1'b1) : den;
         neg_ff[0] <= num[WORD_W-1] ^ den[WORD_W-1];
      end
   end

   for (genvar k = 0; k < WORD_W; k++) begin : g_step
      logic [WORD_W:0] trial_in;
      logic            fits_in;

      always_comb begin
         trial_in = {rem_ff[k], quo_ff[k][WORD_W-1]};
         fits_in  = trial_in >= {1'b0, den_ff[k]};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= fits_in ? WORD_W'(trial_in - {1'b0, den_ff[k]})
                                   : trial_in[WORD_W-1:0];
            quo_ff[k+1] <= {quo_ff[k][WORD_W-2:0], fits_in};
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= neg_ff[WORD_W] ? (~quo_ff[WORD_W] + 1'b1) : quo_ff[WORD_W];
      end
   end

   assign quo = res_ff;
endmodule

@@ rtl/environmental_sensor_compensation.sv @@
// Temperature / pressure / humidity compensation for one raw reading set per beat.
// req channel: one beat carries raw_temp, raw_press and raw_hum in req_tdata.
// rsp channel: one beat per request, in order, with temp_centi, press_q24_8 and
// hum_q22_10 in rsp_tdata and press_valid in rsp_tuser.
// csr channel: writes one calibration word (index 0..4) per beat, always ready;
// write only while no request is in flight.
// A new request is taken every cycle while no response beat is blocked. The
// 64-step pipelined divider sets most of the pipeline depth; the rest includes
// 64-bit multipliers built from 32x32 partial products, two stages each.
// Reset clears the calibration words and every pipeline valid bit.
// When the receiver holds rsp_tready low with a response pending, the whole
// pipeline freezes and req_tready drops in the same cycle; nothing is lost.
module environmental_sensor_compensation (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // raw_temp, raw_press, raw_hum
   input  logic [esc_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // temp_centi, press_q24_8, hum_q22_10, zero pad
   output logic [esc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // press_valid
   output logic [esc_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [esc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [esc_pkg::WORD_W-1:0]         csr_wdata
);
   import esc_pkg::*;

   logic en;
   logic [LATENCY-1:0] vld_ff;

   logic [47:0] temp_cal_ff;
   logic [63:0] press_lo_ff;
   logic [63:0] press_hi_ff;
   logic [47:0] hum_lo_ff;
   logic [31:0] hum_hi_ff;

   logic        [15:0] t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
   logic        [7:0]  h1, h3;
   logic signed [11:0] h4, h5;
   logic signed [7:0]  h6;

   // config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff <= '0;
         press_lo_ff <= '0;
         press_hi_ff <= '0;
         hum_lo_ff   <= '0;
         hum_hi_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_addr)
            CSR_TEMP:     temp_cal_ff <= csr_wdata[47:0];
            CSR_PRESS_LO: press_lo_ff <= csr_wdata;
            CSR_PRESS_HI: press_hi_ff <= csr_wdata;
            CSR_HUM_LO:   hum_lo_ff   <= csr_wdata[47:0];
            CSR_HUM_HI:   hum_hi_ff   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   assign t1 = temp_cal_ff[15:0];
   assign t2 = temp_cal_ff[31:16];
   assign t3 = temp_cal_ff[47:32];
   assign p1 = press_lo_ff[15:0];
   assign p2 = press_lo_ff[31:16];
   assign p3 = press_lo_ff[47:32];
   assign p4 = press_lo_ff[63:48];
   assign p5 = press_hi_ff[15:0];
   assign p6 = press_hi_ff[31:16];
   assign p7 = press_hi_ff[47:32];
   assign p8 = press_hi_ff[63:48];
   assign p9 = hum_lo_ff[15:0];
   assign h1 = hum_lo_ff[23:16];
   assign h2 = hum_lo_ff[39:24];
   assign h3 = hum_lo_ff[47:40];
   assign h4 = hum_hi_ff[11:0];
   assign h5 = hum_hi_ff[23:12];
   assign h6 = hum_hi_ff[31:24];

   // flow control: everything advances together
   assign rsp_tvalid = vld_ff[LATENCY-1];
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LATENCY-2:0], req_tvalid};
      end
   end

   // temperature
   logic signed [18:0] a_in, a_ff;
   logic signed [17:0] b_in, b_ff;
   logic [RAW_P_W-1:0] rp1_ff, rp2_ff, rp3_ff, rp4_ff, rp5_ff;
   logic [RAW_H_W-1:0] rh1_ff, rh2_ff, rh3_ff, rh4_ff, rh5_ff, rh6_ff;
   logic signed [34:0] m1_in, m1_ff;
   logic signed [35:0] bb_in, bb_ff;
   logic signed [23:0] v1_in, v1_ff;
   logic signed [21:0] bbs;
   logic signed [37:0] m2_in, m2_ff;
   logic signed [25:0] fine_in, fine_ff;
   logic [TEMP_W-1:0]  temp_in, temp5_ff, temp13;
   logic signed [26:0] x1_in, x1_ff;
   logic [31:0]        vh_in, vh_ff;

   assign a_in = {2'b00, req_tdata[RAW_T_W-1:3]} - {2'b00, t1, 1'b0};
   assign b_in = {2'b00, req_tdata[RAW_T_W-1:4]} - {2'b00, t1};

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         rp1_ff <= req_tdata[RAW_T_W+RAW_P_W-1:RAW_T_W];
         rh1_ff <= req_tdata[REQ_DATA_W-1:RAW_T_W+RAW_P_W];
      end
   end

   assign m1_in = a_ff * t2;
   assign bb_in = b_ff * b_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff  <= m1_in;
         bb_ff  <= bb_in;
         rp2_ff <= rp1_ff;
         rh2_ff <= rh1_ff;
      end
   end

   assign v1_in = 24'(m1_ff >>> 11);
   assign bbs   = 22'(bb_ff >>> 12);
   assign m2_in = bbs * t3;

   always_ff @(posedge clock) begin
      if (en) begin
         v1_ff  <= v1_in;
         m2_ff  <= m2_in;
         rp3_ff <= rp2_ff;
         rh3_ff <= rh2_ff;
      end
   end

   assign fine_in = 26'(v1_ff) + 26'(m2_ff >>> 14);

   always_ff @(posedge clock) begin
      if (en) begin
         fine_ff <= fine_in;
         rp4_ff  <= rp3_ff;
         rh4_ff  <= rh3_ff;
      end
   end

   assign temp_in = TEMP_W'((29'(fine_ff) * 29'sd5 + 29'sd128) >>> 8);
   assign x1_in   = 27'(fine_ff) - FINE_OFF_P;
   assign vh_in   = 32'(fine_ff) - FINE_OFF_H;

   always_ff @(posedge clock) begin
      if (en) begin
         temp5_ff <= temp_in;
         x1_ff    <= x1_in;
         vh_ff    <= vh_in;
         rp5_ff   <= rp4_ff;
         rh5_ff   <= rh4_ff;
      end
   end

   esc_delay #(.WIDTH(TEMP_W), .DEPTH(TEMP_ALIGN)) u_temp_align (
      .clock(clock), .en(en), .din(temp5_ff), .dout(temp13)
   );

   // stage 6: first products of both branches
   logic signed [53:0] sq_in, sq_ff;
   logic signed [42:0] x1p5_in, x1p5_ff, x1p2_in, x1p2_ff;
   logic [20:0]        pa0_in, pa0_ff;
   logic [31:0]        h5v_in, h5v_ff, vh6_in, vh6_ff, vh3_in, vh3_ff;

   assign sq_in   = x1_ff * x1_ff;
   assign x1p5_in = x1_ff * p5;
   assign x1p2_in = x1_ff * p2;
   assign pa0_in  = PA_BASE - 21'(rp5_ff);
   assign h5v_in  = vh_ff * 32'(h5);
   assign vh6_in  = vh_ff * 32'(h6);
   assign vh3_in  = vh_ff * 32'(h3);

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff   <= sq_in;
         x1p5_ff <= x1p5_in;
         x1p2_ff <= x1p2_in;
         pa0_ff  <= pa0_in;
         h5v_ff  <= h5v_in;
         vh6_ff  <= vh6_in;
         vh3_ff  <= vh3_in;
         rh6_ff  <= rh5_ff;
      end
   end

   // pressure, divisor and dividend
   logic [WORD_W-1:0] m6, m3, mp1, mn;
   logic [106:0]      side8;
   logic [WORD_W-1:0] x2_in, x2_ff, x1b_in, x1b_ff;
   logic [20:0]       pa0_9_ff;
   logic [WORD_W-1:0] t47_in, t47_ff, np_in, np_ff;
   logic [WORD_W-1:0] den_in, den_ff, num_ff;

   esc_mul64 u_mul_p6 (
      .clock(clock), .en(en), .a(64'(sq_ff)), .b(64'(p6)), .p(m6)
   );
   esc_mul64 u_mul_p3 (
      .clock(clock), .en(en), .a(64'(sq_ff)), .b(64'(p3)), .p(m3)
   );
   esc_delay #(.WIDTH(107), .DEPTH(MUL_LAT)) u_side8 (
      .clock(clock), .en(en), .din({x1p5_ff, x1p2_ff, pa0_ff}), .dout(side8)
   );

   assign x2_in  = m6 + (64'($signed(side8[106:64])) << 17) + (64'(p4) << 35);
   assign x1b_in = 64'($signed(m3) >>> 8) + (64'($signed(side8[63:21])) << 12);

   always_ff @(posedge clock) begin
      if (en) begin
         x2_ff    <= x2_in;
         x1b_ff   <= x1b_in;
         pa0_9_ff <= side8[20:0];
      end
   end

   assign t47_in = (64'(1) << 47) + x1b_ff;
   assign np_in  = (64'(pa0_9_ff) << 31) - x2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         t47_ff <= t47_in;
         np_ff  <= np_in;
      end
   end

   esc_mul64 u_mul_p1 (
      .clock(clock), .en(en), .a(t47_ff), .b(64'(p1)), .p(mp1)
   );
   esc_mul64 u_mul_scale (
      .clock(clock), .en(en), .a(np_ff), .b(PRESS_SCALE), .p(mn)
   );

   assign den_in = 64'($signed(mp1) >>> 33);

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff <= den_in;
         num_ff <= mn;
      end
   end

   // humidity, 32-bit wrapping arithmetic
   logic [31:0] hx_in, hx7_ff, hx8_ff, hx9_ff;
   logic [31:0] a6_in, a6_ff, b3_in, b3_ff;
   logic [31:0] inner_in, inner_ff, hyp_in, hyp_ff;
   logic [31:0] hy, hv_in, hv_ff, hv12_ff, s15, sq15_in, sq15_ff, tt_in, tt_ff;
   logic [31:0] hd;
   logic [HUM_W-1:0] hum_in, hum_ff;

   assign hx_in = 32'($signed((32'(rh6_ff) << 14) - (32'(h4) << 20) - h5v_ff
                  + 32'd16384) >>> 15);
   assign a6_in = 32'($signed(vh6_ff) >>> 10);
   assign b3_in = 32'($signed(vh3_ff) >>> 11) + 32'd32768;

   always_ff @(posedge clock) begin
      if (en) begin
         hx7_ff <= hx_in;
         a6_ff  <= a6_in;
         b3_ff  <= b3_in;
      end
   end

   assign inner_in = a6_ff * b3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         inner_ff <= inner_in;
         hx8_ff   <= hx7_ff;
      end
   end

   assign hyp_in = (32'($signed(inner_ff) >>> 10) + 32'd2097152) * 32'(h2);

   always_ff @(posedge clock) begin
      if (en) begin
         hyp_ff <= hyp_in;
         hx9_ff <= hx8_ff;
      end
   end

   assign hy    = 32'($signed(hyp_ff + 32'd8192) >>> 14);
   assign hv_in = hx9_ff * hy;

   always_ff @(posedge clock) begin
      if (en) begin
         hv_ff <= hv_in;
      end
   end

   assign s15     = 32'($signed(hv_ff) >>> 15);
   assign sq15_in = s15 * s15;

   always_ff @(posedge clock) begin
      if (en) begin
         sq15_ff <= sq15_in;
         hv12_ff <= hv_ff;
      end
   end

   assign tt_in = 32'($signed(sq15_ff) >>> 7) * 32'(h1);

   always_ff @(posedge clock) begin
      if (en) begin
         tt_ff <= tt_in;
      end
   end

   // hv12_ff moves on at the same edge as tt_ff, so hold it one stage more
   logic [31:0] hv13_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         hv13_ff <= hv12_ff;
      end
   end

   assign hd = hv13_ff - 32'($signed(tt_ff) >>> 4);

   always_comb begin
      if (hd[31]) begin
         hum_in = '0;
      end else if (hd > HUM_MAX) begin
         hum_in = HUM_MAX[28:12];
      end else begin
         hum_in = hd[28:12];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hum_ff <= hum_in;
      end
   end

   // divider and the values that ride alongside it
   logic [WORD_W-1:0] q;
   logic [TEMP_W+HUM_W:0] side85;

   esc_div u_div (
      .clock(clock), .en(en), .num(num_ff), .den(den_ff), .quo(q)
   );

   esc_delay #(.WIDTH(TEMP_W+HUM_W+1), .DEPTH(SIDE_DEPTH)) u_side85 (
      .clock(clock), .en(en), .din({temp13, hum_ff, den_ff != '0}), .dout(side85)
   );

   // pressure correction terms
   logic [WORD_W-1:0] ss, y2m, y1m, q81;
   logic [2*WORD_W-1:0] side83;
   logic [WORD_W-1:0] sum_in, sum_ff, pb_in, pb_ff;

   esc_mul64 u_mul_ss (
      .clock(clock), .en(en), .a(64'($signed(q) >>> 13)), .b(64'($signed(q) >>> 13)),
      .p(ss)
   );
   esc_mul64 u_mul_p8 (
      .clock(clock), .en(en), .a(64'(p8)), .b(q), .p(y2m)
   );
   esc_delay #(.WIDTH(WORD_W), .DEPTH(MUL_LAT)) u_q81 (
      .clock(clock), .en(en), .din(q), .dout(q81)
   );
   esc_mul64 u_mul_p9 (
      .clock(clock), .en(en), .a(64'(p9)), .b(ss), .p(y1m)
   );
   esc_delay #(.WIDTH(2*WORD_W), .DEPTH(MUL_LAT)) u_side83 (
      .clock(clock), .en(en), .din({q81, y2m}), .dout(side83)
   );

   assign sum_in = side83[2*WORD_W-1:WORD_W] + 64'($signed(y1m) >>> 25)
                 + 64'($signed(side83[WORD_W-1:0]) >>> 19);

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sum_in;
      end
   end

   assign pb_in = 64'($signed(sum_ff) >>> 8) + (64'(p7) << 4);

   always_ff @(posedge clock) begin
      if (en) begin
         pb_ff <= pb_in;
      end
   end

   // output register
   logic [TEMP_W-1:0]  temp_o_ff;
   logic [PRESS_W-1:0] press_o_in, press_o_ff;
   logic [HUM_W-1:0]   hum_o_ff;
   logic               pval_o_ff;

   always_comb begin
      if (!side85[0] || pb_ff[WORD_W-1]) begin
         press_o_in = '0;
      end else if (pb_ff[WORD_W-2:PRESS_W] != '0) begin
         press_o_in = '1;
      end else begin
         press_o_in = pb_ff[PRESS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         temp_o_ff  <= side85[TEMP_W+HUM_W:HUM_W+1];
         hum_o_ff   <= side85[HUM_W:1];
         pval_o_ff  <= side85[0];
         press_o_ff <= press_o_in;
      end
   end

   assign rsp_tdata = {{(RSP_DATA_W-RSP_USED_W){1'b0}}, hum_o_ff, press_o_ff, temp_o_ff};
   assign rsp_tuser = pval_o_ff;
endmodule

@@ rtl/esc_checker.sv @@
`include "environmental_sensor_compensation_assert.svh"

module esc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [esc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [esc_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import esc_pkg::*;

   `ESC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled beat changed")

   // request side only stalls when a response beat is blocked
   `ESC_ASSERT(a_req_ready, clock, reset, req_tready == (!rsp_tvalid || rsp_tready),
      "req_tready does not follow the response stall")

   `ESC_ASSERT(a_press_zero, clock, reset,
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[RSP_HUM_LSB-1:RSP_PRESS_LSB] == '0),
      "pressure nonzero with press_valid low")

   `ESC_ASSERT(a_hum_range, clock, reset,
      rsp_tvalid |-> (rsp_tdata[RSP_USED_W-1:RSP_HUM_LSB] <= HUM_FULL),
      "humidity above full scale")
endmodule

bind environmental_sensor_compensation esc_checker u_esc_checker (.*);

@@ test/testbench.sv @@
module testbench;
   import esc_pkg::*;

   typedef struct packed {
      logic [TEMP_W-1:0]  temp;
      logic [PRESS_W-1:0] press;
      logic               press_ok;
      logic [HUM_W-1:0]   hum;
   } reading_type;

   typedef struct {
      bit [RAW_T_W-1:0] raw_t;
      bit [RAW_P_W-1:0] raw_p;
      bit [RAW_H_W-1:0] raw_h;
      bit               typed;
      reading_type      want;
   } row_type;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RESET_ROWS   = 4;
   localparam int PHASE_ITEMS  = 180;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [WORD_W-1:0]     csr_wdata = '0;

   // calibration copy kept by the predictor
   bit [47:0] cal_temp;
   bit [63:0] cal_plo, cal_phi;
   bit [47:0] cal_hlo;
   bit [31:0] cal_hhi;

   reading_type pending_readings[$];
   int       errors = 0;
   int       cycles = 0;
   int       idle_pct = 33;

   environmental_sensor_compensation dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit [63:0] asr64(bit [63:0] x, int n);
      return $signed(x) >>> n;
   endfunction

   function automatic bit [31:0] asr32(bit [31:0] x, int n);
      return $signed(x) >>> n;
   endfunction

   function automatic bit [63:0] sx16(bit [15:0] x);
      return {{48{x[15]}}, x};
   endfunction

   // signed divide truncating toward zero, min / -1 wraps
   function automatic bit [63:0] sdiv64(bit [63:0] n, bit [63:0] d);
      bit [63:0] mn, md, q;
      mn = n[63] ? -n : n;
      md = d[63] ? -d : d;
      q = mn / md;
      return (n[63] != d[63]) ? -q : q;
   endfunction

   function automatic reading_type compensate(bit [19:0] rt, bit [19:0] rp, bit [15:0] rh);
      bit [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      bit [63:0] a, b, fine, tc, x1, x2, pa, s, y1, y2;
      bit [31:0] h1, h2, h3, h4, h5, h6, v, hx, inner, hy, s15;
      reading_type r;
      t1 = {48'd0, cal_temp[15:0]};
      t2 = sx16(cal_temp[31:16]);
      t3 = sx16(cal_temp[47:32]);
      p1 = {48'd0, cal_plo[15:0]};
      p2 = sx16(cal_plo[31:16]);
      p3 = sx16(cal_plo[47:32]);
      p4 = sx16(cal_plo[63:48]);
      p5 = sx16(cal_phi[15:0]);
      p6 = sx16(cal_phi[31:16]);
      p7 = sx16(cal_phi[47:32]);
      p8 = sx16(cal_phi[63:48]);
      p9 = sx16(cal_hlo[15:0]);
      h1 = {24'd0, cal_hlo[23:16]};
      h2 = {{16{cal_hlo[39]}}, cal_hlo[39:24]};
      h3 = {24'd0, cal_hlo[47:40]};
      h4 = {{20{cal_hhi[11]}}, cal_hhi[11:0]};
      h5 = {{20{cal_hhi[23]}}, cal_hhi[23:12]};
      h6 = {{24{cal_hhi[31]}}, cal_hhi[31:24]};

      a = ({44'd0, rt} >> 3) - (t1 << 1);
      b = ({44'd0, rt} >> 4) - t1;
      fine = asr64(a * t2, 11) + asr64(asr64(b * b, 12) * t3, 14);
      tc = asr64(fine * 64'd5 + 64'd128, 8);
      r.temp = tc[TEMP_W-1:0];

      x1 = fine - 64'd128000;
      x2 = x1 * x1 * p6;
      x2 = x2 + ((x1 * p5) << 17);
      x2 = x2 + (p4 << 35);
      x1 = asr64(x1 * x1 * p3, 8) + ((x1 * p2) << 12);
      x1 = asr64(((64'd1 << 47) + x1) * p1, 33);
      r.press = '0;
      r.press_ok = 1'b0;
      if (x1 != 0) begin
         pa = 64'd1048576 - {44'd0, rp};
         pa = sdiv64(((pa << 31) - x2) * 64'd3125, x1);
         s = asr64(pa, 13);
         y1 = asr64(p9 * s * s, 25);
         y2 = asr64(p8 * pa, 19);
         pa = asr64(pa + y1 + y2, 8) + (p7 << 4);
         if (pa[63]) r.press = '0;
         else if (pa > 64'hFFFF_FFFF) r.press = '1;
         else r.press = pa[31:0];
         r.press_ok = 1'b1;
      end

      v = fine[31:0] - 32'd76800;
      hx = asr32(({16'd0, rh} << 14) - (h4 << 20) - (h5 * v) + 32'd16384, 15);
      inner = asr32(v * h6, 10) * (asr32(v * h3, 11) + 32'd32768);
      hy = asr32((asr32(inner, 10) + 32'd2097152) * h2 + 32'd8192, 14);
      v = hx * hy;
      s15 = asr32(v, 15);
      v = v - asr32(asr32(s15 * s15, 7) * h1, 4);
      if (v[31]) v = '0;
      if (v > HUM_MAX) v = HUM_MAX;
      r.hum = v[28:12];
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s: got %0h expected %0h", field, got, want);
      errors++;
   endtask

   // response side
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata[63:0], 64'd0);
         end else begin
            want = pending_readings.pop_front();
            if (rsp_tdata[TEMP_W-1:0] !== want.temp)
               report_mismatch("temp_centi", 64'(rsp_tdata[TEMP_W-1:0]), 64'(want.temp));
            if (rsp_tdata[RSP_PRESS_LSB +: PRESS_W] !== want.press)
               report_mismatch("press_q24_8", 64'(rsp_tdata[RSP_PRESS_LSB +: PRESS_W]),
                               64'(want.press));
            if (rsp_tuser[0] !== want.press_ok)
               report_mismatch("press_valid", 64'(rsp_tuser[0]), 64'(want.press_ok));
            if (rsp_tdata[RSP_HUM_LSB +: HUM_W] !== want.hum)
               report_mismatch("hum_q22_10", 64'(rsp_tdata[RSP_HUM_LSB +: HUM_W]),
                               64'(want.hum));
            if (rsp_tdata[RSP_DATA_W-1:RSP_USED_W] !== '0)
               report_mismatch("pad bits", 64'(rsp_tdata[RSP_DATA_W-1:RSP_USED_W]), 64'd0);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, logic [WORD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TEMP:     cal_temp = value[47:0];
         CSR_PRESS_LO: cal_plo = value;
         CSR_PRESS_HI: cal_phi = value;
         CSR_HUM_LO:   cal_hlo = value[47:0];
         CSR_HUM_HI:   cal_hhi = value[31:0];
         default: ;
      endcase
   endtask

   task automatic load_calib(bit [63:0] t, bit [63:0] pl, bit [63:0] ph, bit [63:0] hl,
                             bit [63:0] hh);
      write_csr(CSR_TEMP, t);
      write_csr(CSR_PRESS_LO, pl);
      write_csr(CSR_PRESS_HI, ph);
      write_csr(CSR_HUM_LO, hl);
      write_csr(CSR_HUM_HI, hh);
   endtask

   task automatic send_reading(bit [19:0] rt, bit [19:0] rp, bit [15:0] rh, bit typed,
                               reading_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {rh, rp, rt};
      do @(posedge clock); while (!req_tready);
      pending_readings.push_back(typed ? want : compensate(rt, rp, rh));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   bit [63:0] typ_t, typ_pl, typ_ph, typ_hl, typ_hh;
   row_type rows[14];

   initial begin
      reading_type none;
      bit [19:0] rt, rp;
      bit [15:0] rh;
      none = '0;
      // zero calibration: zero divisor, everything reads as zero
      rows[0]  = '{20'd0, 20'd0, 16'd0, 1'b1, none};
      rows[1]  = '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1, none};
      rows[2]  = '{20'd519888, 20'd415148, 16'd30000, 1'b1, none};
      rows[3]  = '{20'hAAAAA, 20'h55555, 16'h5A5A, 1'b1, none};
      // typical calibration from here on
      rows[4]  = '{20'd519888, 20'd415148, 16'd30000, 1'b0, none};
      rows[5]  = '{20'd0, 20'd0, 16'd0, 1'b0, none};
      rows[6]  = '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0, none};
      rows[7]  = '{20'd0, 20'hFFFFF, 16'd0, 1'b0, none};
      rows[8]  = '{20'hFFFFF, 20'd0, 16'hFFFF, 1'b0, none};
      rows[9]  = '{20'd519888, 20'd0, 16'hFFFF, 1'b0, none};
      rows[10] = '{20'd519888, 20'hFFFFF, 16'd0, 1'b0, none};
      rows[11] = '{20'd400000, 20'd300000, 16'd45000, 1'b0, none};
      rows[12] = '{20'd600000, 20'd250000, 16'd20000, 1'b0, none};
      rows[13] = '{20'h80000, 20'h80000, 16'h8000, 1'b0, none};

      typ_t  = 64'({16'(-1000), 16'(26435), 16'(27504)});
      typ_pl = {16'(2855), 16'(3024), 16'(-10685), 16'(36477)};
      typ_ph = {16'(-14600), 16'(15500), 16'(-7), 16'(140)};
      typ_hl = 64'({8'(0), 16'(362), 8'(75), 16'(6000)});
      typ_hh = 64'({8'(30), 12'(50), 12'(313)});

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 14; i++) begin
         if (i == RESET_ROWS) begin
            drain();
            load_calib(typ_t, typ_pl, typ_ph, typ_hl, typ_hh);
         end
         send_reading(rows[i].raw_t, rows[i].raw_p, rows[i].raw_h, rows[i].typed,
                      rows[i].want);
      end

      for (int phase = 0; phase < 7; phase++) begin
         drain();
         idle_pct = (phase == 1) ? 0 : 33;
         case (phase)
            0, 1: load_calib(typ_t, typ_pl, typ_ph, typ_hl, typ_hh);
            2: load_calib('1, '1, '1, '1, '1);
            3: load_calib(64'h7FFF_8000_FFFF, 64'h8000_7FFF_8000_FFFF,
                          64'h7FFF_8000_7FFF_8000, 64'hFF_7FFF_FF_8000,
                          64'h7F_800_7FF);
            4, 5: load_calib({$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom});
            // zero P1 keeps the pressure divisor at zero
            default: load_calib(typ_t, {typ_pl[63:16], 16'd0}, typ_ph, typ_hl, typ_hh);
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(99) < 70) begin
               rt = 20'($urandom_range(600000, 400000));
               rp = 20'($urandom_range(450000, 250000));
               rh = 16'($urandom_range(45000, 15000));
            end else begin
               rt = 20'($urandom);
               rp = 20'($urandom);
               rh = 16'($urandom);
            end
            send_reading(rt, rp, rh, 1'b0, none);
         end
      end

      drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
